// ===== src/rdsc_pkg.sv =====
// Shared types and constants for the radix digit string converter.
// No dependencies; imported by rdsc_cell, rdsc_row and the top level.
package rdsc_pkg;

  localparam int DIGIT_W   = 4;
  localparam int CHAR_W    = 8;
  localparam int BASE_W    = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_HIGH = 2'd2;

  localparam logic [BASE_W-1:0] DIGIT_BASE_RESET    = 5'd16;
  localparam logic [63:0]       ALPHABET_LOW_RESET  = 64'h3736_3534_3332_3130;
  localparam logic [63:0]       ALPHABET_HIGH_RESET = 64'h6665_6463_6261_3938;

  // control from the sequencer into the digit row
  typedef struct packed {
    logic clr;     // start of a new item
    logic feed;    // a value bit enters cell 0
    logic bit_in;  // that bit, MSB first
    logic shift;   // move digits one cell toward the top
  } rdsc_row_ctl_t;

  // status from the digit row back to the sequencer
  typedef struct packed {
    logic               done;       // carry wavefront has left the row
    logic               ovf;        // value needs more digits than the row holds
    logic [DIGIT_W-1:0] top_digit;
  } rdsc_row_sts_t;

endpackage

// ===== src/rdsc_cell.sv =====
// One digit cell: doubles its digit, adds the incoming carry, reduces by the base.
// Also acts as one stage of the output shift line. Depends on rdsc_pkg.
module rdsc_cell import rdsc_pkg::*; (
  input  logic               clk,
  input  logic [BASE_W-1:0]  base,
  input  logic               clr,
  input  logic               en,
  input  logic               cin,
  input  logic               shift,
  input  logic [DIGIT_W-1:0] shift_in,
  output logic [DIGIT_W-1:0] digit,
  output logic               cout
);

  logic [DIGIT_W-1:0] digit_r, digit_nxt;
  logic               carry_r, carry_nxt;
  logic [BASE_W-1:0]  dbl;
  logic [BASE_W-1:0]  red;
  logic               ge;

  // digit < base, so 2*digit + 1 < 2*base and one subtract is enough
  assign dbl = {digit_r, cin};
  assign ge  = (dbl >= base);
  assign red = dbl - base;

  always_comb begin
    digit_nxt = digit_r;
    carry_nxt = carry_r;
    priority if (clr) begin
      digit_nxt = '0;
      carry_nxt = 1'b0;
    end else if (en) begin
      digit_nxt = ge ? red[DIGIT_W-1:0] : dbl[DIGIT_W-1:0];
      carry_nxt = ge;
    end else if (shift) begin
      digit_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
    carry_r <= carry_nxt;
  end

  assign digit = digit_r;
  assign cout  = carry_r;

endmodule

// ===== src/rdsc_row.sv =====
// Row of digit cells, least significant digit in cell 0, with the skewed
// enable line that walks the carry wavefront up the row. Depends on rdsc_pkg, rdsc_cell.
module rdsc_row import rdsc_pkg::*; #(
  parameter int MAX_DIGITS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BASE_W-1:0] base,
  input  rdsc_row_ctl_t     ctl,
  output rdsc_row_sts_t     sts
);

  logic [MAX_DIGITS-1:0] en_r, en_nxt;
  logic                  ovf_r, ovf_nxt;

  logic [DIGIT_W-1:0] digit_w [MAX_DIGITS];
  logic               cout_w  [MAX_DIGITS];

  // cell i takes each value bit after cell i-1; carries are registered between cells
  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    logic               en_i;
    logic               cin_i;
    logic [DIGIT_W-1:0] sin_i;

    if (i == 0) begin : g_first
      assign en_i  = ctl.feed;
      assign cin_i = ctl.bit_in;
      assign sin_i = '0;
    end else begin : g_rest
      assign en_i  = en_r[i-1];
      assign cin_i = cout_w[i-1];
      assign sin_i = digit_w[i-1];
    end

    rdsc_cell u_cell (
      .clk      (clk),
      .base     (base),
      .clr      (ctl.clr),
      .en       (en_i),
      .cin      (cin_i),
      .shift    (ctl.shift),
      .shift_in (sin_i),
      .digit    (digit_w[i]),
      .cout     (cout_w[i])
    );
  end

  always_comb begin
    if (ctl.clr) begin
      en_nxt  = '0;
      ovf_nxt = 1'b0;
    end else begin
      en_nxt  = {en_r[MAX_DIGITS-2:0], ctl.feed};
      // a carry out of the top cell means digits beyond the row
      ovf_nxt = ovf_r | (en_r[MAX_DIGITS-1] & cout_w[MAX_DIGITS-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r  <= '0;
      ovf_r <= 1'b0;
    end else begin
      en_r  <= en_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign sts.done      = (en_r == '0);
  assign sts.ovf       = ovf_r;
  assign sts.top_digit = digit_w[MAX_DIGITS-1];

endmodule

// ===== src/radix_digit_string_converter.sv =====
// Unsigned integer to base-N character string, most significant digit first.
// Busy for each item while the value bits are fed and the carry wavefront runs through
//   the digit cell row, then while the row is shifted out, one cell per cycle; leading zeros give no beat.
// A new item is taken only while idle.
// Reset: synchronous, active low; idles the sequencer and restores the register defaults.
module radix_digit_string_converter import rdsc_pkg::*; #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_BASE   = 16,
  parameter int MAX_DIGITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [63:0]          in_value,
  output logic                 out_strobe,
  output logic [CHAR_W-1:0]    out_digit_char,
  output logic                 out_last_digit,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  localparam int FEED_W = $clog2(VALUE_BITS + 1);
  localparam int EMIT_W = $clog2(MAX_DIGITS + 1);
  localparam logic [BASE_W-1:0] MAX_BASE_V = BASE_W'(MAX_BASE);
  localparam logic [BASE_W-1:0] MIN_BASE_V = BASE_W'(2);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [BASE_W-1:0] digit_base_r;
  logic [63:0]       alphabet_low_r, alphabet_high_r;

  logic [1:0]            state_r, state_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [FEED_W-1:0]     feed_left_r, feed_left_nxt;
  logic [EMIT_W-1:0]     emit_left_r, emit_left_nxt;
  logic                  seen_r, seen_nxt;

  logic                  out_strobe_r, out_strobe_nxt;
  logic [CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic              accept;
  logic [BASE_W-1:0] base_eff;
  logic              leading;
  rdsc_row_ctl_t     row_ctl;
  rdsc_row_sts_t     row_sts;

  function automatic logic [CHAR_W-1:0] char_of(input logic [DIGIT_W-1:0] d,
                                                input logic [63:0] lo,
                                                input logic [63:0] hi);
    logic [63:0] w;
    w = d[3] ? hi : lo;
    return w[{d[2:0], 3'b000} +: CHAR_W];
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_base_r    <= DIGIT_BASE_RESET;
      alphabet_low_r  <= ALPHABET_LOW_RESET;
      alphabet_high_r <= ALPHABET_HIGH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DIGIT_BASE:    digit_base_r    <= cfg_data[BASE_W-1:0];
        CFG_ALPHABET_LOW:  alphabet_low_r  <= cfg_data;
        CFG_ALPHABET_HIGH: alphabet_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (digit_base_r < MIN_BASE_V) base_eff = MIN_BASE_V;
    else if (digit_base_r > MAX_BASE_V)     base_eff = MAX_BASE_V;
    else                                    base_eff = digit_base_r;
  end

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign row_ctl.clr    = accept;
  assign row_ctl.feed   = (state_r == ST_CONV) && (feed_left_r != '0);
  assign row_ctl.bit_in = val_r[VALUE_BITS-1];
  assign row_ctl.shift  = (state_r == ST_EMIT);

  rdsc_row #(.MAX_DIGITS(MAX_DIGITS)) u_row (
    .clk   (clk),
    .rst_n (rst_n),
    .base  (base_eff),
    .ctl   (row_ctl),
    .sts   (row_sts)
  );

  // leading zeros stay silent unless the row overflowed or this is the final digit
  assign leading = !seen_r && !row_sts.ovf && (row_sts.top_digit == '0) &&
                   (emit_left_r != EMIT_W'(1));

  always_comb begin
    state_nxt      = state_r;
    val_nxt        = val_r;
    feed_left_nxt  = feed_left_r;
    emit_left_nxt  = emit_left_r;
    seen_nxt       = seen_r;
    out_strobe_nxt = 1'b0;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt     = ST_CONV;
          val_nxt       = in_value[VALUE_BITS-1:0];
          feed_left_nxt = FEED_W'(VALUE_BITS);
        end
      end
      ST_CONV: begin
        if (feed_left_r != '0) begin
          val_nxt       = {val_r[VALUE_BITS-2:0], 1'b0};
          feed_left_nxt = feed_left_r - FEED_W'(1);
        end else if (row_sts.done) begin
          state_nxt     = ST_EMIT;
          emit_left_nxt = EMIT_W'(MAX_DIGITS);
          seen_nxt      = 1'b0;
        end
      end
      ST_EMIT: begin
        if (!leading) begin
          out_strobe_nxt = 1'b1;
          out_char_nxt   = char_of(row_sts.top_digit, alphabet_low_r, alphabet_high_r);
          out_last_nxt   = (emit_left_r == EMIT_W'(1));
          seen_nxt       = 1'b1;
        end
        emit_left_nxt = emit_left_r - EMIT_W'(1);
        if (emit_left_r == EMIT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      feed_left_r  <= '0;
      emit_left_r  <= '0;
      seen_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      feed_left_r  <= feed_left_nxt;
      emit_left_r  <= emit_left_nxt;
      seen_r       <= seen_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;

endmodule

// ===== src/rdsc_checker.sv =====
// Port-level checks for the radix digit string converter, bound to the top level.
// Depends on radix_digit_string_converter only.
module rdsc_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input logic out_last_digit
);

  // an accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted item");

  // a new item never produces a beat right after its acceptance
  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_strobe)
    else $error("result beat right after acceptance");

  // every beat but the last of a number is shown while the item is still in flight
  a_beat_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last_digit) |-> busy)
    else $error("non-final digit beat while idle");

  // the final digit is never followed directly by another beat
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_digit) |=> !out_strobe)
    else $error("beat directly after the final digit");

  // reset idles the block
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_strobe))
    else $error("block not idle after reset");

endmodule

bind radix_digit_string_converter rdsc_checker u_rdsc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_strobe     (out_strobe),
  .out_last_digit (out_last_digit)
);
